>>> rtl/cea_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous extent allocator package
// Command and result codes, field widths and shared types.
// ----------------------------------------------------------------------------
package cea_pkg;

   localparam int CMD_W   = 2;
   localparam int START_W = 12;
   localparam int LEN_W   = 13;
   localparam int SIZE_W  = 25;
   localparam int CODE_W  = 3;
   localparam int TOTAL_W = 13;
   // quotient of the size plus one for the round-up
   localparam int NEED_W  = SIZE_W + 1;

   localparam logic [CMD_W-1:0] CMD_RESIZE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REINIT  = 2'd3;

   localparam logic [CODE_W-1:0] RC_UNCHANGED  = 3'd0;
   localparam logic [CODE_W-1:0] RC_FRESH      = 3'd1;
   localparam logic [CODE_W-1:0] RC_EXTENDED   = 3'd2;
   localparam logic [CODE_W-1:0] RC_RELOCATED  = 3'd3;
   localparam logic [CODE_W-1:0] RC_SHRUNK     = 3'd4;
   localparam logic [CODE_W-1:0] RC_NO_SPACE   = 3'd5;
   localparam logic [CODE_W-1:0] RC_RANGE_DONE = 3'd6;

   typedef struct packed {
      logic              done;
      logic [NEED_W-1:0] need;
   } div_result_type;

endpackage

>>> rtl/cea_ifc.sv
// ----------------------------------------------------------------------------
// Contiguous extent allocator channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface cea_req_if;
   logic                         valid;
   logic                         ready;
   logic [cea_pkg::CMD_W-1:0]    command;
   logic [cea_pkg::START_W-1:0]  start_block;
   logic [cea_pkg::LEN_W-1:0]    extent_len;
   logic [cea_pkg::SIZE_W-1:0]   size_bytes;
   modport source (output valid, command, start_block, extent_len, size_bytes, input ready);
   modport sink   (input valid, command, start_block, extent_len, size_bytes, output ready);
endinterface

interface cea_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cea_pkg::CODE_W-1:0]   result_code;
   logic [cea_pkg::START_W-1:0]  result_start;
   logic [cea_pkg::LEN_W-1:0]    result_len;
   logic [cea_pkg::TOTAL_W-1:0]  free_left;
   modport source (output valid, result_code, result_start, result_len, free_left, input ready);
   modport sink   (input valid, result_code, result_start, result_len, free_left, output ready);
endinterface

interface cea_csr_if;
   logic                         valid;
   logic                         ready;
   logic [cea_pkg::TOTAL_W-1:0]  block_total;
   modport source (output valid, block_total, input ready);
   modport sink   (input valid, block_total, output ready);
endinterface

>>> rtl/cea_map.sv
// ----------------------------------------------------------------------------
// Used map store
// One bit per block, one port, registered read data.
// ----------------------------------------------------------------------------
module cea_map #(
   parameter int MAP_BLOCKS = 4096
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [$clog2(MAP_BLOCKS)-1:0] addr,
   input  logic                          wdata,
   output logic                          rdata
);
   logic mem [MAP_BLOCKS];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/cea_div.sv
// ----------------------------------------------------------------------------
// Block size divider
// Rounds the byte size up to whole blocks into a registered result: a shift for the
// quotient and a test of the low bits for the round-up. The block size is a
// power of two.
// ----------------------------------------------------------------------------
module cea_div #(
   parameter int BLOCK_BYTES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cea_pkg::SIZE_W-1:0]    dividend,
   output cea_pkg::div_result_type       result
);
   localparam int SHIFT = $clog2(BLOCK_BYTES);
   localparam logic [cea_pkg::SIZE_W-1:0] LOW_MASK = cea_pkg::SIZE_W'(BLOCK_BYTES - 1);

   logic                        done_ff;
   logic [cea_pkg::NEED_W-1:0]  need_ff, need_in;

   assign need_in = cea_pkg::NEED_W'(dividend >> SHIFT)
                  + cea_pkg::NEED_W'((dividend & LOW_MASK) != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
      if (start) begin
         need_ff <= need_in;
      end
   end

   assign result.done = done_ff;
   assign result.need = need_ff;
endmodule

>>> rtl/cea_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the used map one block at a time: clearing sweep, range set and
// clear, run check and first-fit search; holds the free count and the
// response register.
// ----------------------------------------------------------------------------
module cea_ctrl #(
   parameter int MAP_BLOCKS      = 4096,
   parameter int RESERVED_BLOCKS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   cea_req_if.sink                         req_chan,
   cea_rsp_if.source                       rsp_chan,
   input  logic [cea_pkg::TOTAL_W-1:0]     total,
   input  cea_pkg::div_result_type         div_res,
   output logic                            div_start,
   output logic                            map_we,
   output logic [$clog2(MAP_BLOCKS)-1:0]   map_addr,
   output logic                            map_wdata,
   input  logic                            map_rdata
);
   localparam int AW = $clog2(MAP_BLOCKS);
   localparam int CW = ((AW > cea_pkg::TOTAL_W) ? AW : cea_pkg::TOTAL_W) + 1;
   localparam int NW = cea_pkg::NEED_W;
   localparam int FW = cea_pkg::TOTAL_W;
   localparam logic [CW-1:0] RES  = CW'(RESERVED_BLOCKS);
   localparam logic [CW-1:0] LAST = CW'(MAP_BLOCKS - 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CLEAR    = 4'd1;
   localparam logic [3:0] S_DIV      = 4'd2;
   localparam logic [3:0] S_DECIDE   = 4'd3;
   localparam logic [3:0] S_RANGE_RD = 4'd4;
   localparam logic [3:0] S_RANGE_WR = 4'd5;
   localparam logic [3:0] S_SCAN_RD  = 4'd6;
   localparam logic [3:0] S_SCAN_CHK = 4'd7;
   localparam logic [3:0] S_NEXT     = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   localparam logic [3:0] ST_BOOT    = 4'd0;
   localparam logic [3:0] ST_REINIT  = 4'd1;
   localparam logic [3:0] ST_SHRINK  = 4'd2;
   localparam logic [3:0] ST_FRESH   = 4'd3;
   localparam logic [3:0] ST_INPLACE = 4'd4;
   localparam logic [3:0] ST_RELOC   = 4'd5;
   localparam logic [3:0] ST_RELCLR  = 4'd6;
   localparam logic [3:0] ST_FINAL   = 4'd7;
   localparam logic [3:0] ST_MARK    = 4'd8;
   localparam logic [3:0] ST_RELEASE = 4'd9;

   logic [3:0]                   state_ff, state_in;
   logic [3:0]                   step_ff, step_in;
   logic [CW-1:0]                start_ff, start_in;
   logic [CW-1:0]                len_ff, len_in;
   logic [NW-1:0]                need_ff, need_in;
   logic [cea_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [cea_pkg::START_W-1:0]  rs_ff, rs_in;
   logic [cea_pkg::LEN_W-1:0]    rl_ff, rl_in;
   logic [FW-1:0]                fc_ff, fc_in;
   logic [CW-1:0]                cur_ff, cur_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [CW-1:0]                run_ff, run_in;
   logic [CW-1:0]                nf_ff, nf_in;
   logic                         set_ff, set_in;
   logic                         fit_ff, fit_in;
   logic                         oob_ff, oob_in;
   logic                         hit_ff, hit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cea_pkg::CODE_W-1:0]   rsp_code_ff;
   logic [cea_pkg::START_W-1:0]  rsp_start_ff;
   logic [cea_pkg::LEN_W-1:0]    rsp_len_ff;
   logic [FW-1:0]                rsp_free_ff;
   logic                         rsp_load;

   logic [CW-1:0]  total_c;
   logic [NW-1:0]  len_n;
   logic [NW-1:0]  extra;
   logic [CW:0]    fc_sum;
   logic           used;
   logic           req_fire;

   assign total_c   = CW'(total);
   assign len_n     = NW'(len_ff);
   assign extra     = need_ff - len_n;
   assign used      = oob_ff | map_rdata;
   assign req_fire  = req_chan.valid & req_chan.ready;
   assign div_start = req_fire && (req_chan.command == cea_pkg::CMD_RESIZE);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      need_in   = need_ff;
      code_in   = code_ff;
      rs_in     = rs_ff;
      rl_in     = rl_ff;
      fc_in     = fc_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      nf_in     = nf_ff;
      set_in    = set_ff;
      fit_in    = fit_ff;
      oob_in    = oob_ff;
      hit_in    = hit_ff;
      map_we    = 1'b0;
      map_wdata = set_ff;
      rsp_load  = 1'b0;
      fc_sum    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               start_in = CW'(req_chan.start_block);
               len_in   = CW'(req_chan.extent_len);
               code_in  = cea_pkg::RC_RANGE_DONE;
               rs_in    = req_chan.start_block;
               rl_in    = req_chan.extent_len;
               cur_in   = CW'(req_chan.start_block);
               cnt_in   = CW'(req_chan.extent_len);
               case (req_chan.command)
                  cea_pkg::CMD_RESIZE: begin
                     state_in = S_DIV;
                  end
                  cea_pkg::CMD_MARK: begin
                     set_in   = 1'b1;
                     step_in  = ST_MARK;
                     state_in = S_RANGE_RD;
                  end
                  cea_pkg::CMD_RELEASE: begin
                     set_in   = 1'b0;
                     step_in  = ST_RELEASE;
                     state_in = S_RANGE_RD;
                  end
                  default: begin
                     rs_in    = '0;
                     rl_in    = '0;
                     cur_in   = '0;
                     step_in  = ST_REINIT;
                     state_in = S_CLEAR;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            map_we    = 1'b1;
            map_wdata = (cur_ff < RES) && (cur_ff < total_c);
            cur_in    = cur_ff + 1'b1;
            if (cur_ff == LAST) begin
               fc_in    = (total_c > RES) ? FW'(total_c - RES) : '0;
               state_in = (step_ff == ST_REINIT) ? S_DONE : S_IDLE;
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               need_in  = div_res.need;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (need_ff == len_n) begin
               code_in  = cea_pkg::RC_UNCHANGED;
               state_in = S_DONE;
            end else if (need_ff < len_n) begin
               // drop the tail beyond the new length
               cur_in  = start_ff + need_ff[CW-1:0];
               cnt_in  = len_ff - need_ff[CW-1:0];
               set_in  = 1'b0;
               fc_sum  = (CW+1)'(fc_ff) + (CW+1)'(len_ff - need_ff[CW-1:0]);
               if (fc_sum <= (CW+1)'(total_c)) begin
                  fc_in = FW'(fc_sum);
               end
               code_in  = cea_pkg::RC_SHRUNK;
               rl_in    = cea_pkg::LEN_W'(need_ff);
               if (need_ff == '0) begin
                  rs_in = '0;
               end
               step_in  = ST_SHRINK;
               state_in = S_RANGE_RD;
            end else if (NW'(fc_ff) < extra) begin
               code_in  = cea_pkg::RC_NO_SPACE;
               state_in = S_DONE;
            end else if (len_ff == '0) begin
               if (need_ff > NW'(total)) begin
                  code_in  = cea_pkg::RC_NO_SPACE;
                  state_in = S_DONE;
               end else begin
                  cur_in   = RES;
                  run_in   = '0;
                  cnt_in   = need_ff[CW-1:0];
                  fit_in   = 1'b1;
                  step_in  = ST_FRESH;
                  state_in = S_SCAN_RD;
               end
            end else begin
               // blocks just past the extent must all be free
               cur_in   = start_ff + len_ff;
               cnt_in   = extra[CW-1:0];
               fit_in   = 1'b0;
               step_in  = ST_INPLACE;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            oob_in   = cur_ff >= total_c;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cur_in = cur_ff + 1'b1;
            if (fit_ff) begin
               if (oob_ff) begin
                  hit_in   = 1'b0;
                  state_in = S_NEXT;
               end else if (used) begin
                  run_in   = '0;
                  state_in = S_SCAN_RD;
               end else if (run_ff + 1'b1 == cnt_ff) begin
                  nf_in    = cur_ff - cnt_ff + 1'b1;
                  hit_in   = 1'b1;
                  state_in = S_NEXT;
               end else begin
                  run_in   = run_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (used) begin
                  hit_in   = 1'b0;
                  state_in = S_NEXT;
               end else if (cnt_ff == CW'(1)) begin
                  hit_in   = 1'b1;
                  state_in = S_NEXT;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_RANGE_RD: begin
            oob_in   = cur_ff >= total_c;
            state_in = (cnt_ff == '0) ? S_NEXT : S_RANGE_WR;
         end
         S_RANGE_WR: begin
            if (!oob_ff) begin
               map_we = 1'b1;
               if (step_ff == ST_MARK && !map_rdata && fc_ff != '0) begin
                  fc_in = fc_ff - 1'b1;
               end
            end
            cur_in   = cur_ff + 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            state_in = S_RANGE_RD;
         end
         S_NEXT: begin
            state_in = S_DONE;
            case (step_ff)
               ST_FRESH: begin
                  if (hit_ff) begin
                     code_in  = cea_pkg::RC_FRESH;
                     rs_in    = cea_pkg::START_W'(nf_ff);
                     rl_in    = cea_pkg::LEN_W'(need_ff);
                     fc_in    = fc_ff - FW'(need_ff);
                     cur_in   = nf_ff;
                     cnt_in   = need_ff[CW-1:0];
                     set_in   = 1'b1;
                     step_in  = ST_FINAL;
                     state_in = S_RANGE_RD;
                  end else begin
                     code_in = cea_pkg::RC_NO_SPACE;
                  end
               end
               ST_INPLACE: begin
                  if (hit_ff) begin
                     code_in  = cea_pkg::RC_EXTENDED;
                     rl_in    = cea_pkg::LEN_W'(need_ff);
                     fc_in    = fc_ff - FW'(extra);
                     cur_in   = start_ff + len_ff;
                     cnt_in   = extra[CW-1:0];
                     set_in   = 1'b1;
                     step_in  = ST_FINAL;
                     state_in = S_RANGE_RD;
                  end else if (need_ff > NW'(total)) begin
                     code_in = cea_pkg::RC_NO_SPACE;
                  end else begin
                     cur_in   = RES;
                     run_in   = '0;
                     cnt_in   = need_ff[CW-1:0];
                     fit_in   = 1'b1;
                     step_in  = ST_RELOC;
                     state_in = S_SCAN_RD;
                  end
               end
               ST_RELOC: begin
                  if (hit_ff) begin
                     code_in  = cea_pkg::RC_RELOCATED;
                     rs_in    = cea_pkg::START_W'(nf_ff);
                     rl_in    = cea_pkg::LEN_W'(need_ff);
                     fc_in    = fc_ff - FW'(extra);
                     cur_in   = start_ff;
                     cnt_in   = len_ff;
                     set_in   = 1'b0;
                     step_in  = ST_RELCLR;
                     state_in = S_RANGE_RD;
                  end else begin
                     code_in = cea_pkg::RC_NO_SPACE;
                  end
               end
               ST_RELCLR: begin
                  cur_in   = nf_ff;
                  cnt_in   = need_ff[CW-1:0];
                  set_in   = 1'b1;
                  step_in  = ST_FINAL;
                  state_in = S_RANGE_RD;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            // hold until the previous response has been taken
            if (!rsp_valid_ff) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff & ~rsp_chan.ready) | rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= ST_BOOT;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff <= start_in;
      len_ff   <= len_in;
      need_ff  <= need_in;
      code_ff  <= code_in;
      rs_ff    <= rs_in;
      rl_ff    <= rl_in;
      fc_ff    <= fc_in;
      cnt_ff   <= cnt_in;
      run_ff   <= run_in;
      nf_ff    <= nf_in;
      set_ff   <= set_in;
      fit_ff   <= fit_in;
      oob_ff   <= oob_in;
      hit_ff   <= hit_in;
      if (rsp_load) begin
         rsp_code_ff  <= code_ff;
         rsp_start_ff <= rs_ff;
         rsp_len_ff   <= rl_ff;
         rsp_free_ff  <= fc_ff;
      end
   end

   assign map_addr              = cur_ff[AW-1:0];
   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_code  = rsp_code_ff;
   assign rsp_chan.result_start = rsp_start_ff;
   assign rsp_chan.result_len   = rsp_len_ff;
   assign rsp_chan.free_left    = rsp_free_ff;

   a_range_write_in_volume: assert property (@(posedge clock) disable iff (reset)
      (map_we && state_ff != S_CLEAR) |-> (cur_ff < total_c))
      else $error("map write outside the volume");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer idle after a request transfer");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside completion");

   a_fit_above_reserved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT && hit_ff && (step_ff == ST_FRESH || step_ff == ST_RELOC))
      |-> (nf_ff >= RES))
      else $error("first fit landed in the reserved blocks");
endmodule

>>> rtl/contiguous_extent_allocator.sv
// ----------------------------------------------------------------------------
// Contiguous extent allocator
// Used-map block allocator for one file extent: resize, mark, release, reinit.
// ----------------------------------------------------------------------------
// One request is in flight at a time and each gives one response. The map is
// a one-bit-per-block single-port memory, visited one block at a time (read,
// then write or check). A resize first rounds the byte size up to blocks (a
// shift, as BLOCK_BYTES is a power of two) and chooses the outcome, then
// checks, searches or writes one block at a time; mark and release step
// through the blocks of the range, and a reinit, like the pass after reset,
// rewrites the whole map while no request is taken.
// ----------------------------------------------------------------------------
module contiguous_extent_allocator #(
   parameter int MAP_BLOCKS      = 4096,
   parameter int BLOCK_BYTES     = 4096,
   parameter int RESERVED_BLOCKS = 2
) (
   input  logic         clock,
   input  logic         reset,
   cea_req_if.sink      req_chan,
   cea_rsp_if.source    rsp_chan,
   cea_csr_if.sink      csr_chan
);
   localparam int AW = $clog2(MAP_BLOCKS);

   logic [cea_pkg::TOTAL_W-1:0] block_total_ff, block_total_in;
   logic [cea_pkg::TOTAL_W-1:0] total;
   cea_pkg::div_result_type     div_res;
   logic                        div_start;
   logic                        map_we;
   logic [AW-1:0]               map_addr;
   logic                        map_wdata;
   logic                        map_rdata;

   assign csr_chan.ready = 1'b1;
   assign block_total_in = (csr_chan.valid & csr_chan.ready) ? csr_chan.block_total
                                                              : block_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_total_ff <= cea_pkg::TOTAL_W'(4096);
      end else begin
         block_total_ff <= block_total_in;
      end
   end

   // clamp the volume to the map
   assign total = (32'(block_total_ff) > MAP_BLOCKS) ? cea_pkg::TOTAL_W'(MAP_BLOCKS)
                                                     : block_total_ff;

   cea_div #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_chan.size_bytes),
      .result   (div_res)
   );

   cea_map #(
      .MAP_BLOCKS(MAP_BLOCKS)
   ) u_map (
      .clock (clock),
      .we    (map_we),
      .addr  (map_addr),
      .wdata (map_wdata),
      .rdata (map_rdata)
   );

   cea_ctrl #(
      .MAP_BLOCKS      (MAP_BLOCKS),
      .RESERVED_BLOCKS (RESERVED_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .total     (total),
      .div_res   (div_res),
      .div_start (div_start),
      .map_we    (map_we),
      .map_addr  (map_addr),
      .map_wdata (map_wdata),
      .map_rdata (map_rdata)
   );
endmodule

>>> verif/contiguous_extent_allocator_tb.sv
// ----------------------------------------------------------------------------
// Contiguous extent allocator testbench
// Drives resize, mark, release and reinit requests through the request channel
// and checks each response against a model of the used map and free count.
// The block total is rewritten between phases, while the block is idle.
// ----------------------------------------------------------------------------
module contiguous_extent_allocator_tb;

   localparam int MAP_BLOCKS      = 4096;
   localparam int BLOCK_BYTES     = 4096;
   localparam int RESERVED_BLOCKS = 2;
   localparam int IDLE_LIMIT      = 200000;
   localparam int NUM_FILES       = 4;

   typedef struct packed {
      logic [cea_pkg::CMD_W-1:0]   command;
      logic [cea_pkg::START_W-1:0] start_block;
      logic [cea_pkg::LEN_W-1:0]   extent_len;
      logic [cea_pkg::SIZE_W-1:0]  size_bytes;
   } alloc_req_type;

   typedef struct packed {
      logic [cea_pkg::CODE_W-1:0]  result_code;
      logic [cea_pkg::START_W-1:0] result_start;
      logic [cea_pkg::LEN_W-1:0]   result_len;
      logic [cea_pkg::TOTAL_W-1:0] free_left;
   } alloc_rsp_type;

   typedef struct packed {
      logic [MAP_BLOCKS-1:0]       used;
      logic [cea_pkg::TOTAL_W-1:0] free_cnt;
      logic [cea_pkg::TOTAL_W-1:0] total_reg;
   } volume_type;

   logic clock;
   logic reset;

   cea_req_if req_if ();
   cea_rsp_if rsp_if ();
   cea_csr_if csr_if ();

   contiguous_extent_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   volume_type    plan_vol;   // advanced as requests are queued, steers the generator
   volume_type    live_vol;   // advanced as requests are accepted by the block
   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   alloc_req_type cur_req;
   int            err_count;
   int            idle_cycles;
   bit            req_taken;
   int            burst_left;
   int            gap_left;
   int            hold_cnt;
   bit            hold_req;
   int            rx_mode;
   int            rx_cnt;
   int            file_start[NUM_FILES];
   int            file_len[NUM_FILES];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic int eff_total(input logic [cea_pkg::TOTAL_W-1:0] t);
      return (t > MAP_BLOCKS) ? MAP_BLOCKS : int'(t);
   endfunction

   function automatic bit block_busy(input volume_type v, input int b);
      if (b >= eff_total(v.total_reg)) return 1'b1;
      return v.used[b];
   endfunction

   function automatic void fill_range(inout volume_type v, input int first, input int n,
                                      input bit val);
      int total;
      total = eff_total(v.total_reg);
      for (int i = 0; i < n; i++)
         if (first + i < total) v.used[first + i] = val;
   endfunction

   function automatic bit find_run(input volume_type v, input int n, output int found);
      int total;
      int s;
      bit ok;
      total = eff_total(v.total_reg);
      s = RESERVED_BLOCKS;
      found = 0;
      if (n == 0) return 1'b1;
      if (n > total) return 1'b0;
      while (s + n <= total) begin
         ok = 1'b1;
         for (int j = 0; j < n; j++) begin
            if (block_busy(v, s + j)) begin
               ok = 1'b0;
               s = s + j + 1;
               break;
            end
         end
         if (ok) begin
            found = s;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void wipe_volume(inout volume_type v);
      int total;
      total = eff_total(v.total_reg);
      v.used = '0;
      for (int i = 0; i < RESERVED_BLOCKS; i++)
         if (i < total) v.used[i] = 1'b1;
      v.free_cnt = cea_pkg::TOTAL_W'((total > RESERVED_BLOCKS) ? total - RESERVED_BLOCKS : 0);
   endfunction

   function automatic void alloc_step(inout volume_type v, input alloc_req_type rq,
                                      output alloc_rsp_type rs);
      int total, start, len, need, extra, nf, fc, newly, b;
      bit can;
      total = eff_total(v.total_reg);
      start = rq.start_block;
      len   = rq.extent_len;
      fc    = v.free_cnt;
      rs.result_code  = cea_pkg::RC_RANGE_DONE;
      rs.result_start = rq.start_block;
      rs.result_len   = rq.extent_len;
      case (rq.command)
         cea_pkg::CMD_RESIZE: begin
            need = (rq.size_bytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
            if (need == len) begin
               rs.result_code = cea_pkg::RC_UNCHANGED;
            end else if (need < len) begin
               fill_range(v, start + need, len - need, 1'b0);
               if (fc + (len - need) <= total) fc = fc + (len - need);
               rs.result_code = cea_pkg::RC_SHRUNK;
               rs.result_len  = cea_pkg::LEN_W'(need);
               if (need == 0) rs.result_start = '0;
            end else begin
               extra = need - len;
               if (fc < extra) begin
                  rs.result_code = cea_pkg::RC_NO_SPACE;
               end else if (len == 0) begin
                  if (find_run(v, need, nf)) begin
                     fill_range(v, nf, need, 1'b1);
                     fc = fc - need;
                     rs.result_code  = cea_pkg::RC_FRESH;
                     rs.result_start = cea_pkg::START_W'(nf);
                     rs.result_len   = cea_pkg::LEN_W'(need);
                  end else begin
                     rs.result_code = cea_pkg::RC_NO_SPACE;
                  end
               end else begin
                  can = 1'b1;
                  for (int i = 0; i < extra; i++)
                     if (block_busy(v, start + len + i)) begin
                        can = 1'b0;
                        break;
                     end
                  if (can) begin
                     fill_range(v, start + len, extra, 1'b1);
                     fc = fc - extra;
                     rs.result_code = cea_pkg::RC_EXTENDED;
                     rs.result_len  = cea_pkg::LEN_W'(need);
                  end else if (find_run(v, need, nf)) begin
                     fill_range(v, start, len, 1'b0);
                     fill_range(v, nf, need, 1'b1);
                     fc = fc - extra;
                     rs.result_code  = cea_pkg::RC_RELOCATED;
                     rs.result_start = cea_pkg::START_W'(nf);
                     rs.result_len   = cea_pkg::LEN_W'(need);
                  end else begin
                     rs.result_code = cea_pkg::RC_NO_SPACE;
                  end
               end
            end
         end
         cea_pkg::CMD_MARK: begin
            newly = 0;
            for (int i = 0; i < len; i++) begin
               b = start + i;
               if (b < total && !v.used[b]) begin
                  v.used[b] = 1'b1;
                  newly++;
               end
            end
            fc = (fc > newly) ? fc - newly : 0;
         end
         cea_pkg::CMD_RELEASE: fill_range(v, start, len, 1'b0);
         default: begin
            wipe_volume(v);
            fc = v.free_cnt;
            rs.result_start = '0;
            rs.result_len   = '0;
         end
      endcase
      v.free_cnt   = fc[cea_pkg::TOTAL_W-1:0];
      rs.free_left = v.free_cnt;
   endfunction

   function automatic void reset_volume(inout volume_type v);
      v.total_reg = cea_pkg::TOTAL_W'(MAP_BLOCKS);
      wipe_volume(v);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   always @(posedge clock) begin : monitor
      alloc_rsp_type want;
      alloc_rsp_type got;
      alloc_req_type rq;
      if (!reset) begin
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) begin
            rq = {req_if.command, req_if.start_block, req_if.extent_len, req_if.size_bytes};
            alloc_step(live_vol, rq, want);
            expected_rsps.push_back(want);
         end
         if (csr_if.valid && csr_if.ready) live_vol.total_reg = csr_if.block_total;
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.result_code, rsp_if.result_start, rsp_if.result_len,
                   rsp_if.free_left};
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response, code", got.result_code, -1);
            end else begin
               want = expected_rsps.pop_front();
               if (got.result_code !== want.result_code)
                  report_mismatch("result_code", got.result_code, want.result_code);
               if (got.result_start !== want.result_start)
                  report_mismatch("result_start", got.result_start, want.result_start);
               if (got.result_len !== want.result_len)
                  report_mismatch("result_len", got.result_len, want.result_len);
               if (got.free_left !== want.free_left)
                  report_mismatch("free_left", got.free_left, want.free_left);
            end
         end
         if (req_taken || (rsp_if.valid && rsp_if.ready) || (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // Offer requests in bursts, hold each until its transfer.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_if.valid       <= 1'b1;
            req_if.command     <= cur_req.command;
            req_if.start_block <= cur_req.start_block;
            req_if.extent_len  <= cur_req.extent_len;
            req_if.size_bytes  <= cur_req.size_bytes;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
         // long hold-off: let requests pile up behind the one in flight
         hold_req = 1'b0;
         hold_cnt = 800;
         rsp_if.ready <= 1'b0;
      end else begin
         rx_cnt++;
         if (rx_cnt % 150 == 0) rx_mode = $urandom_range(0, 2);
         case (rx_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_req(input logic [cea_pkg::CMD_W-1:0] cmd, input int start,
                            input int len, input int size, output alloc_rsp_type rs);
      alloc_req_type rq;
      rq.command     = cmd;
      rq.start_block = cea_pkg::START_W'(start);
      rq.extent_len  = cea_pkg::LEN_W'(len);
      rq.size_bytes  = cea_pkg::SIZE_W'(size);
      alloc_step(plan_vol, rq, rs);
      pending_reqs.push_back(rq);
   endtask

   function automatic int bytes_for(input int need);
      return (need == 0) ? 0 : need * BLOCK_BYTES - $urandom_range(0, BLOCK_BYTES - 1);
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_total(input int value);
      alloc_rsp_type rs;
      wait_drained();
      @(negedge clock);
      csr_if.valid       <= 1'b1;
      csr_if.block_total <= cea_pkg::TOTAL_W'(value);
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      @(negedge clock);
      csr_if.valid <= 1'b0;
      plan_vol.total_reg = cea_pkg::TOTAL_W'(value);
      queue_req(cea_pkg::CMD_REINIT, 0, 0, 0, rs);
      for (int f = 0; f < NUM_FILES; f++) begin
         file_start[f] = 0;
         file_len[f]   = 0;
      end
   endtask

   task automatic run_random(input int n);
      alloc_rsp_type rs;
      int total, sel, f, need, len, span;
      total = eff_total(plan_vol.total_reg);
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            // well-formed resize of one of the tracked extents
            f   = $urandom_range(0, NUM_FILES - 1);
            len = file_len[f];
            case ($urandom_range(0, 5))
               0:       need = len;
               1:       need = (len > 0) ? len - $urandom_range(1, len) : 0;
               2, 3:    need = len + $urandom_range(1, 4);
               4:       need = 0;
               default: need = $urandom_range(1, total / 4 + 1);
            endcase
            queue_req(cea_pkg::CMD_RESIZE, file_start[f], len, bytes_for(need), rs);
            if (rs.result_code != cea_pkg::RC_NO_SPACE) begin
               file_start[f] = rs.result_start;
               file_len[f]   = rs.result_len;
            end
         end else if (sel < 75) begin
            queue_req(cea_pkg::CMD_RESIZE, $urandom_range(0, 4095), $urandom_range(0, 8),
                      $urandom & 32'h1FF_FFFF, rs);
         end else if (sel < 98) begin
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4096)
                                                : $urandom_range(0, 16);
            queue_req((sel < 87) ? cea_pkg::CMD_MARK : cea_pkg::CMD_RELEASE,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, total + 2),
                      span, $urandom & 32'h1FF_FFFF, rs);
         end else begin
            queue_req(cea_pkg::CMD_REINIT, $urandom_range(0, 4095), $urandom_range(0, 4096),
                      $urandom & 32'h1FF_FFFF, rs);
            for (int g = 0; g < NUM_FILES; g++) begin
               file_start[g] = 0;
               file_len[g]   = 0;
            end
         end
      end
   endtask

   initial begin
      alloc_rsp_type rs;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = cea_pkg::CMD_RESIZE;
      req_if.start_block = '0;
      req_if.extent_len  = '0;
      req_if.size_bytes  = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.block_total = '0;
      err_count   = 0;
      idle_cycles = 0;
      req_taken   = 1'b0;
      burst_left  = 0;
      gap_left    = 0;
      hold_cnt    = 0;
      hold_req    = 1'b0;
      rx_mode     = 0;
      rx_cnt      = 0;
      for (int f = 0; f < NUM_FILES; f++) begin
         file_start[f] = 0;
         file_len[f]   = 0;
      end
      reset_volume(plan_vol);
      reset_volume(live_vol);
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: every outcome and the corner cases of the map
      queue_req(cea_pkg::CMD_REINIT,  0,    0,    0,            rs);
      queue_req(cea_pkg::CMD_RESIZE,  0,    0,    0,            rs);  // nothing to do
      queue_req(cea_pkg::CMD_RESIZE,  0,    0,    1,            rs);  // fresh extent at block 2
      queue_req(cea_pkg::CMD_RESIZE,  2,    1,    4096,         rs);  // exact fit, unchanged
      queue_req(cea_pkg::CMD_RESIZE,  2,    1,    3 * 4096,     rs);  // grow in place
      queue_req(cea_pkg::CMD_RESIZE,  0,    0,    8192,         rs);  // second extent after
      queue_req(cea_pkg::CMD_RESIZE,  2,    3,    5 * 4096,     rs);  // blocked, so relocate
      queue_req(cea_pkg::CMD_RESIZE,  7,    5,    4097,         rs);  // shrink the tail
      queue_req(cea_pkg::CMD_RESIZE,  7,    2,    0,            rs);  // shrink to nothing
      queue_req(cea_pkg::CMD_RESIZE,  5,    2,    16777216,     rs);  // too large
      queue_req(cea_pkg::CMD_RESIZE,  0,    0,    32'h1FF_FFFF, rs);
      queue_req(cea_pkg::CMD_RESIZE,  4095, 4096, 32'h1FF_FFFF, rs);
      queue_req(cea_pkg::CMD_MARK,    4095, 4096, 0,            rs);  // mostly beyond volume
      queue_req(cea_pkg::CMD_RELEASE, 0,    4096, 0,            rs);  // count left alone
      queue_req(cea_pkg::CMD_RESIZE,  10,   3,    0,            rs);  // count may not overflow
      queue_req(cea_pkg::CMD_MARK,    0,    4096, 0,            rs);  // count saturates at zero
      queue_req(cea_pkg::CMD_RESIZE,  0,    0,    4096,         rs);  // no free blocks
      queue_req(cea_pkg::CMD_RESIZE,  4093, 1,    4 * 4096,     rs);  // grow past the end
      queue_req(cea_pkg::CMD_RELEASE, 100,  50,   0,            rs);
      queue_req(cea_pkg::CMD_REINIT,  4095, 4096, 32'h1FF_FFFF, rs);
      queue_req(cea_pkg::CMD_RESIZE,  0,    0,    4094 * 4096,  rs);  // whole volume
      queue_req(cea_pkg::CMD_RESIZE,  2,    4094, 0,            rs);
      run_random(120);

      write_total(3);
      run_random(250);
      write_total(100);
      run_random(150);
      wait (pending_reqs.size() < 100);
      hold_req = 1'b1;
      run_random(350);
      write_total(8191);
      run_random(100);
      write_total(1000);
      run_random(400);
      write_total(64);
      run_random(350);

      wait_drained();
      repeat (300) @(posedge clock);
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/cea_pkg.sv
rtl/cea_ifc.sv
rtl/cea_map.sv
rtl/cea_div.sv
rtl/cea_ctrl.sv
rtl/contiguous_extent_allocator.sv
verif/contiguous_extent_allocator_tb.sv
